>>> hdl/iir_pkg.sv
// shared types and constants for the direct form i iir filter
package iir_pkg;

  // fixed field widths
  localparam int SAMPLE_BITS     = 24;
  localparam int COEFF_BITS      = 32;
  localparam int COEFF_INT_BITS  = 4;
  localparam int COEFF_FRAC_BITS = COEFF_BITS - COEFF_INT_BITS;
  localparam int PROD_BITS       = SAMPLE_BITS + COEFF_BITS;
  localparam int ACC_BITS        = 64;
  localparam int COEFF_IDX_BITS  = 4;

  // default tap limits, handed to the top level parameters
  localparam int DEF_MAX_FORWARD_TAPS  = 16;
  localparam int DEF_MAX_FEEDBACK_TAPS = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLED     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_TAP_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_TAP_COUNT = 2'd2;

  // request codes
  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_COEFF  = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_type_t;

  localparam logic COEFF_BANK_FORWARD  = 1'b0;
  localparam logic COEFF_BANK_FEEDBACK = 1'b1;

  typedef struct packed {
    logic [1:0]                    req_type;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic                          coeff_bank;
    logic [COEFF_IDX_BITS-1:0]     coeff_index;
    logic signed [COEFF_BITS-1:0]  coeff_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          saturated;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FWD,
    ST_FB,
    ST_DRAIN
  } fsm_state_t;

  // sequencer to multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic issue;
    logic subtract;
  } mac_ctrl_t;

endpackage

>>> hdl/iir_filter_direct_form1.sv
// top level of the direct form i iir filter with memory-held histories and coefficients
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_data   (iir_pkg::in_item_t)
//   out_     output     out_valid / out_stall out_data  (iir_pkg::out_item_t)
//   cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// a sample beat occupies the block from accept through its nf forward taps, nb
//   feedback taps (nf, nb the clamped tap counts) and drain to the next accept; the one
//   shared multiplier takes one tap per cycle from the memory read ports
// with the filter disabled a sample skips the taps; coefficient and clear beats leave the input unstalled
// reset is synchronous: valid bits of all four memories, positions and registers
//   clear together, no sweep
// a result waits in the output register while the next beat is accepted; a sample
//   that finishes while that register is still stalled holds until it drains
module iir_filter_direct_form1 #(
  parameter int MAX_FORWARD_TAPS  = iir_pkg::DEF_MAX_FORWARD_TAPS,
  parameter int MAX_FEEDBACK_TAPS = iir_pkg::DEF_MAX_FEEDBACK_TAPS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  iir_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output iir_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [iir_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [iir_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import iir_pkg::*;

  localparam int FIDX_W = (MAX_FORWARD_TAPS > 1) ? $clog2(MAX_FORWARD_TAPS) : 1;
  localparam int BIDX_W = (MAX_FEEDBACK_TAPS > 1) ? $clog2(MAX_FEEDBACK_TAPS) : 1;

  // sequencer state
  fsm_state_t state_r, state_nxt;

  // configuration registers
  logic                  en_r;
  logic [CFG_DATA_W-1:0] fcnt_r;
  logic [CFG_DATA_W-1:0] bcnt_r;

  // ring positions, current item positions, read pointers and tap counters
  logic [FIDX_W-1:0] ipos_r, ipos_nxt;
  logic [FIDX_W-1:0] icur_r, icur_nxt;
  logic [FIDX_W-1:0] fp_r, fp_nxt;
  logic [FIDX_W-1:0] fk_r, fk_nxt;
  logic [BIDX_W-1:0] opos_r, opos_nxt;
  logic [BIDX_W-1:0] ocur_r, ocur_nxt;
  logic [BIDX_W-1:0] bp_r, bp_nxt;
  logic [BIDX_W-1:0] bk_r, bk_nxt;
  logic signed [SAMPLE_BITS-1:0] x_r, x_nxt;

  // clamped tap counts
  logic [31:0]       nf32;
  logic [31:0]       nb32;
  logic [FIDX_W-1:0] nf_last;
  logic [BIDX_W-1:0] nb_last;
  logic [FIDX_W-1:0] ipos_eff;
  logic [BIDX_W-1:0] opos_eff;

  // beat decode
  logic in_acc;
  logic acc_sample;
  logic acc_coeff;
  logic acc_clear;
  logic ff_idx_ok;
  logic fb_idx_ok;

  // memory ports
  logic                   ih_we;
  logic [SAMPLE_BITS-1:0] ih_rdata;
  logic                   oh_we;
  logic [SAMPLE_BITS-1:0] oh_wdata;
  logic [SAMPLE_BITS-1:0] oh_rdata;
  logic                   ffc_we;
  logic [COEFF_BITS-1:0]  ffc_rdata;
  logic                   fbc_we;
  logic [COEFF_BITS-1:0]  fbc_rdata;

  // mac and output register
  mac_ctrl_t mac_ctrl;
  logic      mac_busy;
  out_item_t mac_res;
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t out_item_nxt;
  logic      out_free;
  logic      out_load;
  logic      finish;

  // a count of zero acts as one, above the memory depth acts as the depth
  always_comb begin
    nf32 = 32'(fcnt_r);
    if (fcnt_r == '0) begin
      nf32 = 32'd1;
    end else if (32'(fcnt_r) > 32'(MAX_FORWARD_TAPS)) begin
      nf32 = 32'(MAX_FORWARD_TAPS);
    end
    nb32 = 32'(bcnt_r);
    if (bcnt_r == '0) begin
      nb32 = 32'd1;
    end else if (32'(bcnt_r) > 32'(MAX_FEEDBACK_TAPS)) begin
      nb32 = 32'(MAX_FEEDBACK_TAPS);
    end
  end

  assign nf_last = FIDX_W'(nf32 - 32'd1);
  assign nb_last = BIDX_W'(nb32 - 32'd1);

  // a position left beyond a shrunk ring restarts at zero
  assign ipos_eff = (32'(ipos_r) >= nf32) ? '0 : ipos_r;
  assign opos_eff = (32'(opos_r) >= nb32) ? '0 : opos_r;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign acc_sample = in_acc && (in_data.req_type == REQ_SAMPLE);
  assign acc_coeff  = in_acc && (in_data.req_type == REQ_COEFF);
  assign acc_clear  = in_acc && (in_data.req_type == REQ_CLEAR);
  assign ff_idx_ok  = 32'(in_data.coeff_index) < 32'(MAX_FORWARD_TAPS);
  assign fb_idx_ok  = 32'(in_data.coeff_index) < 32'(MAX_FEEDBACK_TAPS);

  // new sample lands in the input ring at accept, before any tap read
  assign ih_we  = acc_sample;
  assign ffc_we = acc_coeff && (in_data.coeff_bank == COEFF_BANK_FORWARD) && ff_idx_ok;
  assign fbc_we = acc_coeff && (in_data.coeff_bank == COEFF_BANK_FEEDBACK) && fb_idx_ok;

  assign out_free = !out_valid_r || !out_stall;
  assign finish   = (state_r == ST_DRAIN) && !mac_busy && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc_sample) begin
          state_nxt = en_r ? ST_FWD : ST_DRAIN;
        end
      end
      ST_FWD: begin
        if (fk_r == nf_last) begin
          state_nxt = ST_FB;
        end
      end
      ST_FB: begin
        if (bk_r == nb_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs and datapath register updates
  always_comb begin
    mac_ctrl = '0;
    ipos_nxt = ipos_r;
    opos_nxt = opos_r;
    icur_nxt = icur_r;
    ocur_nxt = ocur_r;
    fp_nxt   = fp_r;
    fk_nxt   = fk_r;
    bp_nxt   = bp_r;
    bk_nxt   = bk_r;
    x_nxt    = x_r;
    oh_we    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (acc_sample) begin
          mac_ctrl.clear = 1'b1;
          icur_nxt = ipos_eff;
          ocur_nxt = opos_eff;
          fp_nxt   = ipos_eff;
          fk_nxt   = '0;
          // feedback starts one slot behind the write position
          bp_nxt   = (opos_eff == '0) ? nb_last : (opos_eff - BIDX_W'(1));
          bk_nxt   = '0;
          x_nxt    = in_data.in_sample;
        end else if (acc_clear) begin
          ipos_nxt = '0;
          opos_nxt = '0;
        end
      end
      ST_FWD: begin
        mac_ctrl.issue = 1'b1;
        fp_nxt = (fp_r == '0) ? nf_last : (fp_r - FIDX_W'(1));
        fk_nxt = fk_r + FIDX_W'(1);
      end
      ST_FB: begin
        mac_ctrl.issue    = 1'b1;
        mac_ctrl.subtract = 1'b1;
        bp_nxt = (bp_r == '0) ? nb_last : (bp_r - BIDX_W'(1));
        bk_nxt = bk_r + BIDX_W'(1);
      end
      ST_DRAIN: begin
        if (finish) begin
          // output ring written only after every feedback read of this item
          oh_we    = 1'b1;
          out_load = 1'b1;
          ipos_nxt = (icur_r == nf_last) ? '0 : (icur_r + FIDX_W'(1));
          opos_nxt = (ocur_r == nb_last) ? '0 : (ocur_r + BIDX_W'(1));
        end
      end
      default: begin
        mac_ctrl = '0;
      end
    endcase
  end

  // disabled filter passes the sample through unclamped-by-design
  always_comb begin
    out_item_nxt = mac_res;
    if (!en_r) begin
      out_item_nxt.out_sample = x_r;
      out_item_nxt.saturated  = 1'b0;
    end
  end

  assign oh_wdata = out_item_nxt.out_sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ipos_r  <= '0;
      opos_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ipos_r  <= ipos_nxt;
      opos_r  <= opos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    icur_r <= icur_nxt;
    ocur_r <= ocur_nxt;
    fp_r   <= fp_nxt;
    fk_r   <= fk_nxt;
    bp_r   <= bp_nxt;
    bk_r   <= bk_nxt;
    x_r    <= x_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b1;
      fcnt_r <= CFG_DATA_W'(1);
      bcnt_r <= CFG_DATA_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FILTER_ENABLED:     en_r   <= cfg_wdata[0];
        CFG_FORWARD_TAP_COUNT:  fcnt_r <= cfg_wdata;
        CFG_FEEDBACK_TAP_COUNT: bcnt_r <= cfg_wdata;
        default: begin
          en_r <= en_r;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // input history ring
  iir_vram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_FORWARD_TAPS)
  ) u_in_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (acc_clear),
    .we    (ih_we),
    .waddr (ipos_eff),
    .wdata (in_data.in_sample),
    .raddr (fp_r),
    .rdata (ih_rdata)
  );

  // output history ring
  iir_vram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_FEEDBACK_TAPS)
  ) u_out_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (acc_clear),
    .we    (oh_we),
    .waddr (ocur_r),
    .wdata (oh_wdata),
    .raddr (bp_r),
    .rdata (oh_rdata)
  );

  // feed-forward coefficients
  iir_vram #(
    .WIDTH (COEFF_BITS),
    .DEPTH (MAX_FORWARD_TAPS)
  ) u_ff_coef (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (1'b0),
    .we    (ffc_we),
    .waddr (FIDX_W'(in_data.coeff_index)),
    .wdata (in_data.coeff_value),
    .raddr (fk_r),
    .rdata (ffc_rdata)
  );

  // feedback coefficients
  iir_vram #(
    .WIDTH (COEFF_BITS),
    .DEPTH (MAX_FEEDBACK_TAPS)
  ) u_fb_coef (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (1'b0),
    .we    (fbc_we),
    .waddr (BIDX_W'(in_data.coeff_index)),
    .wdata (in_data.coeff_value),
    .raddr (bk_r),
    .rdata (fbc_rdata)
  );

  iir_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .fwd_x (ih_rdata),
    .fwd_c (ffc_rdata),
    .fb_y  (oh_rdata),
    .fb_c  (fbc_rdata),
    .busy  (mac_busy),
    .res   (mac_res)
  );

endmodule

>>> hdl/iir_vram.sv
// synchronous memory with per-entry valid bits, invalid entries read as zero
module iir_vram #(
  parameter int WIDTH = iir_pkg::SAMPLE_BITS,
  parameter int DEPTH = iir_pkg::DEF_MAX_FORWARD_TAPS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   clear,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_data_r;
  logic             rd_vld_r;
  logic [AW-1:0]    unused_aw;

  assign unused_aw = raddr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[unused_aw];
    end
  end

  assign rdata = rd_vld_r ? rd_data_r : '0;

endmodule

>>> hdl/iir_mac.sv
// shared multiply-accumulate unit with output scaling and saturation
module iir_mac (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  iir_pkg::mac_ctrl_t                      ctrl,
  input  logic signed [iir_pkg::SAMPLE_BITS-1:0]  fwd_x,
  input  logic signed [iir_pkg::COEFF_BITS-1:0]   fwd_c,
  input  logic signed [iir_pkg::SAMPLE_BITS-1:0]  fb_y,
  input  logic signed [iir_pkg::COEFF_BITS-1:0]   fb_c,
  output logic                                    busy,
  output iir_pkg::out_item_t                      res
);
  import iir_pkg::*;

  logic                          iss_d_r;
  logic                          sel_fb_r;
  logic signed [SAMPLE_BITS-1:0] op_x;
  logic signed [COEFF_BITS-1:0]  op_c;
  logic signed [PROD_BITS-1:0]   prod_r;
  logic                          prod_v_r;
  logic                          prod_sub_r;
  logic signed [ACC_BITS-1:0]    prod_ext;
  logic signed [ACC_BITS-1:0]    acc_r;
  logic signed [ACC_BITS-1:0]    acc_sh;
  logic [ACC_BITS-SAMPLE_BITS:0] top_bits;
  logic                          fits;

  // tags follow the memory read latency
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_d_r  <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      iss_d_r  <= ctrl.issue;
      prod_v_r <= iss_d_r;
    end
  end

  always_ff @(posedge clk) begin
    sel_fb_r   <= ctrl.subtract;
    prod_sub_r <= sel_fb_r;
    prod_r     <= op_x * op_c;
  end

  assign op_x     = sel_fb_r ? fb_y : fwd_x;
  assign op_c     = sel_fb_r ? fb_c : fwd_c;
  assign prod_ext = ACC_BITS'(prod_r);

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= prod_sub_r ? (acc_r - prod_ext) : (acc_r + prod_ext);
    end
  end

  assign busy = iss_d_r | prod_v_r;

  // back to q1.23 by flooring shift, then clamp
  assign acc_sh   = acc_r >>> COEFF_FRAC_BITS;
  assign top_bits = acc_sh[ACC_BITS-1:SAMPLE_BITS-1];
  assign fits     = (&top_bits) | ~(|top_bits);

  always_comb begin
    res.saturated  = ~fits;
    res.out_sample = acc_sh[SAMPLE_BITS-1:0];
    if (!fits) begin
      res.out_sample = acc_sh[ACC_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                          : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

endmodule

>>> hdl/iir_checker.sv
// port-level checks for the iir filter, bound to the top level
module iir_port_props (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input iir_pkg::in_item_t   in_data,
  input logic                out_valid,
  input logic                out_stall,
  input iir_pkg::out_item_t  out_data
);
  import iir_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] FULL_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] FULL_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // a sample keeps the block busy on the following cycle
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.req_type == REQ_SAMPLE) |=> in_stall)
    else $error("sample accepted without busy interval");

  // a new result appears only out of a busy interval
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat without a sample in work");

  // clamped results sit at full scale
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      (out_data.out_sample == FULL_POS) || (out_data.out_sample == FULL_NEG))
    else $error("saturation flag without full-scale value");

endmodule

bind iir_filter_direct_form1 iir_port_props u_iir_port_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> verif/iir_checker.sv
// checker for the iir filter: tracks config, predicts each filtered sample and compares results
module iir_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  iir_pkg::in_item_t                   in_data,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  iir_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [iir_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [iir_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output int                                  errors,
  output int                                  backlog,
  output int                                  checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import iir_pkg::*;

  localparam int     MAX_F      = DEF_MAX_FORWARD_TAPS;
  localparam int     MAX_B      = DEF_MAX_FEEDBACK_TAPS;
  localparam longint SAT_HI     = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO     = -SAT_HI - 1;

  logic signed [SAMPLE_BITS-1:0] x_ring [MAX_F];
  logic signed [SAMPLE_BITS-1:0] y_ring [MAX_B];
  logic signed [COEFF_BITS-1:0]  ff_coef [MAX_F];
  logic signed [COEFF_BITS-1:0]  fb_coef [MAX_B];
  int unsigned                   x_pos;
  int unsigned                   y_pos;
  logic                          enabled;
  logic [CFG_DATA_W-1:0]         fwd_taps;
  logic [CFG_DATA_W-1:0]         fb_taps;

  out_item_t predicted_samples [$];
  out_item_t want;
  int        mismatches = 0;
  int        results_seen = 0;

  task automatic report_mismatch(string what);
    mismatches++;
    $display("[%0t] iir_checker: result %0d: %s", $time, results_seen, what);
  endtask

  // zero means one tap, anything above the maximum means the maximum
  function automatic int unsigned tap_limit(logic [CFG_DATA_W-1:0] c, int unsigned top);
    if (c == 0)
      return 1;
    return (c > top) ? top : c;
  endfunction

  function automatic void reset_filter();
    foreach (x_ring[i]) begin
      x_ring[i]  = '0;
      ff_coef[i] = '0;
    end
    foreach (y_ring[i]) begin
      y_ring[i]  = '0;
      fb_coef[i] = '0;
    end
    x_pos    = 0;
    y_pos    = 0;
    enabled  = 1'b1;
    fwd_taps = 1;
    fb_taps  = 1;
  endfunction

  function automatic out_item_t filter_sample(logic signed [SAMPLE_BITS-1:0] x);
    int unsigned nf;
    int unsigned nb;
    int unsigned p;
    int unsigned k;
    longint      acc;
    longint      v;
    out_item_t   r;
    nf = tap_limit(fwd_taps, MAX_F);
    nb = tap_limit(fb_taps, MAX_B);
    if (x_pos >= nf)
      x_pos = 0;
    if (y_pos >= nb)
      y_pos = 0;
    x_ring[x_pos] = x;
    r.saturated = 1'b0;
    if (enabled) begin
      acc = 0;
      p = x_pos;
      for (k = 0; k < nf; k++) begin
        acc += longint'(x_ring[p]) * longint'(ff_coef[k]);
        p = (p == 0) ? nf - 1 : p - 1;
      end
      p = (y_pos == 0) ? nb - 1 : y_pos - 1;
      for (k = 0; k < nb; k++) begin
        acc -= longint'(y_ring[p]) * longint'(fb_coef[k]);
        p = (p == 0) ? nb - 1 : p - 1;
      end
      v = acc >>> COEFF_FRAC_BITS;
      if (v > SAT_HI) begin
        v = SAT_HI;
        r.saturated = 1'b1;
      end else if (v < SAT_LO) begin
        v = SAT_LO;
        r.saturated = 1'b1;
      end
      r.out_sample = v[SAMPLE_BITS-1:0];
    end else begin
      r.out_sample = x;
    end
    y_ring[y_pos] = r.out_sample;
    x_pos = (x_pos + 1 == nf) ? 0 : x_pos + 1;
    y_pos = (y_pos + 1 == nb) ? 0 : y_pos + 1;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_filter();
      predicted_samples.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FILTER_ENABLED:     enabled  = cfg_wdata[0];
          CFG_FORWARD_TAP_COUNT:  fwd_taps = cfg_wdata;
          CFG_FEEDBACK_TAP_COUNT: fb_taps  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (in_data.req_type)
          REQ_SAMPLE:
            predicted_samples.push_back(filter_sample(in_data.in_sample));
          REQ_COEFF: begin
            if (in_data.coeff_bank == COEFF_BANK_FORWARD) begin
              if (in_data.coeff_index < MAX_F)
                ff_coef[in_data.coeff_index] = in_data.coeff_value;
            end else begin
              if (in_data.coeff_index < MAX_B)
                fb_coef[in_data.coeff_index] = in_data.coeff_value;
            end
          end
          REQ_CLEAR: begin
            foreach (x_ring[i])
              x_ring[i] = '0;
            foreach (y_ring[i])
              y_ring[i] = '0;
            x_pos = 0;
            y_pos = 0;
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (predicted_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", out_data.out_sample));
        end else begin
          want = predicted_samples.pop_front();
          if (out_data.out_sample !== want.out_sample)
            report_mismatch($sformatf("out_sample %0d, expected %0d",
                                      out_data.out_sample, want.out_sample));
          if (out_data.saturated !== want.saturated)
            report_mismatch($sformatf("saturated %b, expected %b",
                                      out_data.saturated, want.saturated));
        end
        results_seen++;
      end
    end
    errors  <= mismatches;
    backlog <= predicted_samples.size();
    checked <= results_seen;
  end

endmodule

>>> verif/tb.sv
// top level testbench for the direct form i iir filter: stimulus, idling and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iir_pkg::*;

  // request code the block must ignore, and the config index with no register behind it
  localparam logic [1:0]           REQ_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

  localparam int ITEMS         = 400;
  localparam int RANDOM_PHASES = 8;
  localparam int IDLE_PCT      = 11;
  localparam int SETTLE_CYCLES = 40;    // one full sample pass plus margin
  localparam int DRAIN_LIMIT   = 5000;
  localparam int RUN_LIMIT_NS  = 2_000_000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic no_idle = 1'b0;   // quiet stretch: neither side idles
  int   errors;
  int   backlog;
  int   checked;
  int   beats_sent = 0;
  int   settings_run = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  iir_filter_direct_form1 DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  iir_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .backlog   (backlog),
    .checked   (checked)
  );

  // result side back-pressure, random stall cycles except in the quiet stretch
  always @(posedge clk) begin
    if (!rst_n || no_idle)
      out_stall <= 1'b0;
    else
      out_stall <= ($urandom_range(99) < IDLE_PCT);
  end

  // random fill for every field, so fields a request ignores still toggle
  function automatic in_item_t beat_of(logic [1:0] req);
    in_item_t b;
    b.req_type    = req;
    b.in_sample   = SAMPLE_BITS'($urandom);
    b.coeff_bank  = 1'($urandom);
    b.coeff_index = COEFF_IDX_BITS'($urandom);
    b.coeff_value = $urandom;
    return b;
  endfunction

  // half the values scaled down so the filter does not live in saturation,
  // with full-scale and full-width values mixed in
  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    logic signed [SAMPLE_BITS-1:0] s;
    s = SAMPLE_BITS'($urandom);
    case ($urandom_range(7))
      0:       s = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      1:       s = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      2, 3:    ;
      default: s = s >>> $urandom_range(12, 1);
    endcase
    return s;
  endfunction

  function automatic logic signed [COEFF_BITS-1:0] rand_coeff();
    logic signed [COEFF_BITS-1:0] c;
    c = $urandom;
    if ($urandom_range(7) != 0)
      c = c >>> $urandom_range(10, 3);
    return c;
  endfunction

  // present one beat, with random idle cycles ahead of it; holds until accepted
  task automatic send_beat(in_item_t beat);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] s);
    in_item_t b;
    b = beat_of(REQ_SAMPLE);
    b.in_sample = s;
    send_beat(b);
  endtask

  task automatic send_coeff(logic bank, logic [COEFF_IDX_BITS-1:0] idx,
                            logic signed [COEFF_BITS-1:0] value);
    in_item_t b;
    b = beat_of(REQ_COEFF);
    b.coeff_bank  = bank;
    b.coeff_index = idx;
    b.coeff_value = value;
    send_beat(b);
  endtask

  // drop valid, wait for every predicted sample to come out, then let
  // any coefficient or clear beat still in flight finish
  task automatic wait_idle();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (backlog != 0 && guard < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // new filter setting, written only with the block idle; the spare index
  // gets random data and must change nothing
  task automatic set_filter(logic en, logic [CFG_DATA_W-1:0] fwd,
                            logic [CFG_DATA_W-1:0] fb);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FILTER_ENABLED;
    cfg_wdata <= {4'($urandom), en};   // upper bits are don't-care
    @(posedge clk);
    cfg_index <= CFG_FORWARD_TAP_COUNT;
    cfg_wdata <= fwd;
    @(posedge clk);
    cfg_index <= CFG_FEEDBACK_TAP_COUNT;
    cfg_wdata <= fb;
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  initial begin
    int sent;
    int pick;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset setting: enabled, one tap each way
    send_sample(24'sh7FFFFF);                                // all coefficients still zero
    send_coeff(COEFF_BANK_FORWARD, 4'd0, 32'sh1000_0000);    // gain +1.0
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_coeff(COEFF_BANK_FORWARD, 4'd0, 32'shF000_0000);    // gain -1.0
    send_sample(24'sh800000);                                // +1.0 clamps to positive full scale
    send_coeff(COEFF_BANK_FORWARD, 4'd0, 32'sh7FFF_FFFF);    // largest gain
    send_sample(24'sh7FFFFF);                                // clamps high
    send_sample(24'shFFFFFF);                                // -1 lsb, truncation toward minus infinity
    send_coeff(COEFF_BANK_FEEDBACK, 4'd0, 32'sh0800_0000);   // feedback 0.5
    send_coeff(COEFF_BANK_FORWARD, 4'd15, 32'sh8000_0000);   // top index, most negative value
    send_coeff(COEFF_BANK_FEEDBACK, 4'd15, 32'sh8000_0000);
    send_sample(24'sh003039);
    send_beat(beat_of(REQ_UNUSED));                          // ignored, no result
    send_beat(beat_of(REQ_CLEAR));                           // histories cleared, no result
    send_sample(24'sh400000);

    // disabled, with tap counts outside the legal range: straight pass-through
    set_filter(1'b0, 5'd31, 5'd0);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample(rand_sample());

    // enabled with full tap counts, rings keep their positions from before
    set_filter(1'b1, 5'd16, 5'd16);
    repeat (4) send_sample(rand_sample());

    // shrink the rings so the stored positions lie past the new counts
    set_filter(1'b1, 5'd2, 5'd3);
    repeat (2) send_sample(rand_sample());

    // random part: one phase per filter setting, extremes first
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       set_filter(1'b1, 5'd16, 5'd16);
        1:       set_filter(1'b1, 5'd0, 5'd31);
        2:       set_filter(1'b0, 5'($urandom), 5'($urandom));
        3:       set_filter(1'b1, 5'd1, 5'd1);
        default: set_filter($urandom_range(99) < 85, 5'($urandom), 5'($urandom));
      endcase
      no_idle <= (ph == 4);
      sent = 0;
      while (sent < ITEMS / RANDOM_PHASES) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          send_sample(rand_sample());
          sent++;
        end else if (pick < 88) begin
          send_coeff(1'($urandom), COEFF_IDX_BITS'($urandom), rand_coeff());
          sent++;
        end else if (pick < 95) begin
          send_beat(beat_of(REQ_CLEAR));
          sent++;
        end else begin
          send_beat(beat_of(REQ_UNUSED));   // ignored beats are not counted
        end
      end
    end
    no_idle <= 1'b0;

    wait_idle();
    $display("run covered %0d beats over %0d filter settings", beats_sent, settings_run);
    $display("filtered samples compared: %0d, still outstanding: %0d", checked, backlog);
    if (errors == 0 && backlog == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #(RUN_LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
